FILE: hdl/cosem_object_access_lookup_core_defines.svh
// Assertion macros shared by the lookup core.
`ifndef COSEM_OBJECT_ACCESS_LOOKUP_CORE_DEFINES_SVH
`define COSEM_OBJECT_ACCESS_LOOKUP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define COAL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define COAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define COAL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define COAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/coal_pkg.sv
package coal_pkg;

  localparam int OBJECT_DEPTH_DEF   = 64;
  localparam int MEMBER_DEPTH_DEF   = 256;
  localparam int DATABASE_COUNT_DEF = 8;
  localparam int CFG_W              = 7;

  localparam logic [1:0] CMD_WRITE_OBJECT = 2'd0;
  localparam logic [1:0] CMD_WRITE_MEMBER = 2'd1;
  localparam logic [1:0] CMD_LOOKUP       = 2'd2;

  localparam logic [1:0] SVC_GET    = 2'd0;
  localparam logic [1:0] SVC_SET    = 2'd1;
  localparam logic [1:0] SVC_ACTION = 2'd2;

  localparam logic [1:0] NEED_GET  = 2'b01;
  localparam logic [1:0] NEED_SET  = 2'b10;
  localparam logic [1:0] NEED_BOTH = 2'b11;

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  slot;
    logic [15:0] iface_class;
    logic [47:0] obis;
    logic [2:0]  database;
    logic [7:0]  first_member;
    logic [7:0]  attr_count;
    logic [7:0]  method_count;
    logic [7:0]  member_number;
    logic [1:0]  rights;
    logic [7:0]  data_type;
    logic [1:0]  service;
  } req_item_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  found_database;
    logic [5:0]  found_slot;
    logic [7:0]  found_type;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] iface_class;
    logic [47:0] obis;
    logic [2:0]  database;
    logic [7:0]  first_member;
    logic [7:0]  attr_count;
    logic [7:0]  method_count;
  } obj_entry_t;

  typedef struct packed {
    logic [7:0] number;
    logic [1:0] rights;
    logic [7:0] data_type;
  } member_entry_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic obj_read;
    logic obj_load;
    logic obj_next;
    logic mem_read;
    logic mem_next;
    logic res_hit;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lookup_req;
    logic obj_more;
    logic obj_hit;
    logic mem_more;
    logic addr_ok;
    logic mem_hit;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBJ_TEST,
    ST_OBJ_CHECK,
    ST_MEM_TEST,
    ST_MEM_CHECK,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/coal_stream_if.sv
interface coal_req_if;
  logic                valid;
  logic                ready;
  coal_pkg::req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface coal_rsp_if;
  logic                valid;
  logic                ready;
  coal_pkg::rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/coal_datapath.sv
`include "cosem_object_access_lookup_core_defines.svh"

module coal_datapath #(
  parameter int OBJECT_DEPTH   = coal_pkg::OBJECT_DEPTH_DEF,
  parameter int MEMBER_DEPTH   = coal_pkg::MEMBER_DEPTH_DEF,
  parameter int DATABASE_COUNT = coal_pkg::DATABASE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [coal_pkg::CFG_W-1:0]   cfg_write_data,
  input  coal_pkg::req_item_t          item,
  input  coal_pkg::ctrl_cmd_t          cmd,
  output coal_pkg::ctrl_sts_t          sts,
  coal_rsp_if.source                   rsp
);

  localparam int OAW = (OBJECT_DEPTH > 1) ? $clog2(OBJECT_DEPTH) : 1;
  localparam int OCW = $clog2(OBJECT_DEPTH + 1);
  localparam int MAW = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
  localparam int LW  = (OCW > coal_pkg::CFG_W) ? OCW : coal_pkg::CFG_W;

  coal_pkg::obj_entry_t    obj_mem [OBJECT_DEPTH];
  coal_pkg::member_entry_t mem_mem [MEMBER_DEPTH];
  coal_pkg::obj_entry_t    obj_q;
  coal_pkg::member_entry_t mem_q;
  coal_pkg::obj_entry_t    wr_obj_entry;

  logic [coal_pkg::CFG_W-1:0] objects_in_use;
  logic [OCW-1:0]             limit;
  logic [OCW-1:0]             obj_idx;

  logic [15:0] req_class;
  logic [47:0] req_obis;
  logic [7:0]  req_member;
  logic [1:0]  req_service;

  logic [7:0] cur_addr;
  logic [7:0] scan_cnt;
  logic [7:0] scan_len;
  logic [1:0] need;
  logic [7:0] base_next;
  logic [7:0] len_next;
  logic [1:0] need_next;
  logic       svc_ok;

  logic       res_status;
  logic [2:0] res_database;
  logic [5:0] res_slot;
  logic [7:0] res_type;

  logic wr_obj;
  logic wr_mem;

  always_comb begin
    if (LW'(objects_in_use) > LW'(OBJECT_DEPTH)) begin
      limit = OCW'(OBJECT_DEPTH);
    end else begin
      limit = OCW'(objects_in_use);
    end
  end

  assign wr_obj = cmd.accept && (item.command == coal_pkg::CMD_WRITE_OBJECT) &&
                  (9'(item.slot) < 9'(OBJECT_DEPTH));
  assign wr_mem = cmd.accept && (item.command == coal_pkg::CMD_WRITE_MEMBER) &&
                  (9'(item.slot) < 9'(MEMBER_DEPTH));

  always_comb begin
    wr_obj_entry.iface_class  = item.iface_class;
    wr_obj_entry.obis         = item.obis;
    wr_obj_entry.first_member = item.first_member;
    wr_obj_entry.attr_count   = item.attr_count;
    wr_obj_entry.method_count = item.method_count;
    if (4'(item.database) >= 4'(DATABASE_COUNT)) begin
      wr_obj_entry.database = 3'(DATABASE_COUNT - 1);
    end else begin
      wr_obj_entry.database = item.database;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_obj) begin
      obj_mem[item.slot[OAW-1:0]] <= wr_obj_entry;
    end
    if (cmd.obj_read) begin
      obj_q <= obj_mem[obj_idx[OAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      mem_mem[item.slot[MAW-1:0]] <= '{number: item.member_number, rights: item.rights,
                                       data_type: item.data_type};
    end
    if (cmd.mem_read) begin
      mem_q <= mem_mem[cur_addr[MAW-1:0]];
    end
  end

  always_comb begin
    svc_ok    = 1'b1;
    base_next = obj_q.first_member;
    len_next  = obj_q.attr_count;
    need_next = coal_pkg::NEED_GET;
    unique case (req_service)
      coal_pkg::SVC_GET: begin
        need_next = coal_pkg::NEED_GET;
      end
      coal_pkg::SVC_SET: begin
        need_next = coal_pkg::NEED_SET;
      end
      coal_pkg::SVC_ACTION: begin
        need_next = coal_pkg::NEED_BOTH;
        base_next = obj_q.first_member + obj_q.attr_count;
        len_next  = obj_q.method_count;
      end
      default: begin
        svc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    sts.lookup_req = item.command == coal_pkg::CMD_LOOKUP;
    sts.obj_more   = obj_idx < limit;
    sts.obj_hit    = svc_ok && (obj_q.iface_class == req_class) && (obj_q.obis == req_obis);
    sts.mem_more   = scan_cnt < scan_len;
    sts.addr_ok    = 9'(cur_addr) < 9'(MEMBER_DEPTH);
    sts.mem_hit    = (mem_q.number == req_member) && ((mem_q.rights & need) == need);
    sts.out_free   = !rsp.valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      objects_in_use <= '0;
    end else if (cfg_write_en) begin
      objects_in_use <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_class    <= item.iface_class;
      req_obis     <= item.obis;
      req_member   <= item.member_number;
      req_service  <= item.service;
      obj_idx      <= '0;
      res_status   <= coal_pkg::STATUS_NOT_FOUND;
      res_database <= '0;
      res_slot     <= '0;
      res_type     <= '0;
    end
    if (cmd.obj_next) begin
      obj_idx <= obj_idx + 1'b1;
    end
    if (cmd.obj_load) begin
      cur_addr <= base_next;
      scan_len <= len_next;
      scan_cnt <= '0;
      need     <= need_next;
    end
    if (cmd.mem_next) begin
      cur_addr <= cur_addr + 1'b1;
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (cmd.res_hit) begin
      res_status   <= coal_pkg::STATUS_FOUND;
      res_database <= obj_q.database;
      res_slot     <= 6'(obj_idx);
      res_type     <= mem_q.data_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.publish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp.payload <= '{status: res_status, found_database: res_database,
                       found_slot: res_slot, found_type: res_type};
    end
  end

  `COAL_ASSERT_SAME(a_publish_free, clk, rst, cmd.publish, !rsp.valid || rsp.ready, "overwrite")
  `COAL_ASSERT_SAME(a_obj_read_range, clk, rst, cmd.obj_read, obj_idx < limit, "object range")
  `COAL_ASSERT_SAME(a_mem_read_range, clk, rst, cmd.mem_read, sts.addr_ok, "member range")
  `COAL_ASSERT_NEXT(a_hit_status, clk, rst, cmd.res_hit, res_status == coal_pkg::STATUS_FOUND, "hit")

endmodule

FILE: hdl/coal_ctrl.sv
module coal_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  coal_pkg::ctrl_sts_t sts,
  output logic                req_ready,
  output coal_pkg::ctrl_cmd_t cmd
);

  coal_pkg::state_t state;
  coal_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= coal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      coal_pkg::ST_IDLE: begin
        if (req_valid && sts.lookup_req) begin
          state_next = coal_pkg::ST_OBJ_TEST;
        end
      end
      coal_pkg::ST_OBJ_TEST: begin
        state_next = sts.obj_more ? coal_pkg::ST_OBJ_CHECK : coal_pkg::ST_DONE;
      end
      coal_pkg::ST_OBJ_CHECK: begin
        state_next = sts.obj_hit ? coal_pkg::ST_MEM_TEST : coal_pkg::ST_OBJ_TEST;
      end
      coal_pkg::ST_MEM_TEST: begin
        if (!sts.mem_more) begin
          state_next = coal_pkg::ST_OBJ_TEST;
        end else if (sts.addr_ok) begin
          state_next = coal_pkg::ST_MEM_CHECK;
        end
      end
      coal_pkg::ST_MEM_CHECK: begin
        state_next = sts.mem_hit ? coal_pkg::ST_DONE : coal_pkg::ST_MEM_TEST;
      end
      coal_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = coal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = coal_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      coal_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        cmd.start  = req_valid && sts.lookup_req;
      end
      coal_pkg::ST_OBJ_TEST: begin
        cmd.obj_read = sts.obj_more;
      end
      coal_pkg::ST_OBJ_CHECK: begin
        cmd.obj_load = sts.obj_hit;
        cmd.obj_next = !sts.obj_hit;
      end
      coal_pkg::ST_MEM_TEST: begin
        cmd.obj_next = !sts.mem_more;
        cmd.mem_next = sts.mem_more && !sts.addr_ok;
        cmd.mem_read = sts.mem_more && sts.addr_ok;
      end
      coal_pkg::ST_MEM_CHECK: begin
        cmd.res_hit  = sts.mem_hit;
        cmd.mem_next = !sts.mem_hit;
      end
      coal_pkg::ST_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/cosem_object_access_lookup_core.sv
// Channel   Direction  Payload
// req       in         command, table entry fields, lookup key, service
// rsp       out        status, found_database, found_slot, found_type
// cfg       in         objects_in_use, written when cfg_write_en is high
//
// A write command gives no result. A lookup is accepted, then each object slot in use
// is read and checked; on a match, that object's members are read and examined one by
// one (a member slot beyond the table is skipped unread) until a hit or until they run
// out, and the scan then goes on with the next object. A miss ends after the final slot
// test; the output register is then loaded. Each table has a single read port.
// Reset is synchronous and active high; the tables keep no valid bits.
// A finished result waits in the output register, and the next request is accepted
// while it waits; a second lookup result waits for that register to empty.
module cosem_object_access_lookup_core #(
  parameter int OBJECT_DEPTH   = coal_pkg::OBJECT_DEPTH_DEF,
  parameter int MEMBER_DEPTH   = coal_pkg::MEMBER_DEPTH_DEF,
  parameter int DATABASE_COUNT = coal_pkg::DATABASE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [coal_pkg::CFG_W-1:0] cfg_write_data,
  coal_req_if.sink                   req,
  coal_rsp_if.source                 rsp
);

  coal_pkg::ctrl_cmd_t cmd;
  coal_pkg::ctrl_sts_t sts;

  coal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  coal_datapath #(
    .OBJECT_DEPTH   (OBJECT_DEPTH),
    .MEMBER_DEPTH   (MEMBER_DEPTH),
    .DATABASE_COUNT (DATABASE_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (req.payload),
    .cmd            (cmd),
    .sts            (sts),
    .rsp            (rsp)
  );

endmodule

FILE: bench/cosem_object_access_lookup_core_tb.sv
module cosem_object_access_lookup_core_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] SVC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 100000;
  localparam coal_pkg::rsp_item_t NOT_FOUND = '{coal_pkg::STATUS_NOT_FOUND, 3'd0, 6'd0, 8'd0};

  typedef struct {
    bit                  set_cfg;
    logic [6:0]          cfg_value;
    coal_pkg::req_item_t item;
    bit                  pinned;
    coal_pkg::rsp_item_t result;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [coal_pkg::CFG_W-1:0] cfg_write_data;

  coal_req_if req_ch ();
  coal_rsp_if rsp_ch ();

  cosem_object_access_lookup_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req           (req_ch),
    .rsp           (rsp_ch)
  );

  coal_pkg::obj_entry_t    obj_table [coal_pkg::OBJECT_DEPTH_DEF];
  coal_pkg::member_entry_t member_table [coal_pkg::MEMBER_DEPTH_DEF];
  logic [6:0]              scan_count;
  coal_pkg::rsp_item_t     pending_results [$];
  directed_row_t           directed_rows [$];
  logic [15:0]             class_pool [4];
  logic [47:0]             obis_pool [4];

  logic                row_pinned;
  coal_pkg::rsp_item_t row_result;
  coal_pkg::rsp_item_t want;
  int                  error_count;
  int                  quiet_cycles;
  int                  burst_left;
  int                  ready_mode;
  int                  mode_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic coal_pkg::rsp_item_t lookup_result(coal_pkg::req_item_t q);
    coal_pkg::rsp_item_t r;
    int                  lim;
    logic [7:0]          base;
    logic [7:0]          count;
    logic [7:0]          m;
    logic [1:0]          need;
    bit                  hit;
    r = NOT_FOUND;
    hit = 1'b0;
    lim = (scan_count > coal_pkg::OBJECT_DEPTH_DEF) ? coal_pkg::OBJECT_DEPTH_DEF :
                                                      int'(scan_count);
    for (int i = 0; i < lim && !hit; i++) begin
      if (obj_table[i].iface_class == q.iface_class && obj_table[i].obis == q.obis &&
          q.service != SVC_UNUSED) begin
        case (q.service)
          coal_pkg::SVC_GET: need = coal_pkg::NEED_GET;
          coal_pkg::SVC_SET: need = coal_pkg::NEED_SET;
          default: need = coal_pkg::NEED_BOTH;
        endcase
        if (q.service == coal_pkg::SVC_ACTION) begin
          base = obj_table[i].first_member + obj_table[i].attr_count;
          count = obj_table[i].method_count;
        end else begin
          base = obj_table[i].first_member;
          count = obj_table[i].attr_count;
        end
        for (int k = 0; k < int'(count) && !hit; k++) begin
          m = base + 8'(k);
          if (member_table[m].number == q.member_number &&
              (member_table[m].rights & need) == need) begin
            hit = 1'b1;
            r = '{coal_pkg::STATUS_FOUND, obj_table[i].database, 6'(i),
                  member_table[m].data_type};
          end
        end
      end
    end
    return r;
  endfunction

  function automatic coal_pkg::req_item_t make_request(
    logic [1:0] cmd, logic [7:0] slot, logic [15:0] cls, logic [47:0] obis,
    logic [2:0] db, logic [7:0] fm, logic [7:0] ac, logic [7:0] mc,
    logic [7:0] num, logic [1:0] rights, logic [7:0] dtype, logic [1:0] svc);
    return '{cmd, slot, cls, obis, db, fm, ac, mc, num, rights, dtype, svc};
  endfunction

  task automatic send_request(input coal_pkg::req_item_t item, input bit pinned,
                              input coal_pkg::rsp_item_t result);
    int gap;
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid = 1'b1;
    req_ch.payload = item;
    row_pinned = pinned;
    row_result = result;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_scan_count(input logic [6:0] value);
    drain();
    cfg_write_en = 1'b1;
    cfg_write_data = value;
    scan_count = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("lookup result with none expected: %p", rsp_ch.payload);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.payload.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.payload.status);
            error_count++;
          end
          if (rsp_ch.payload.found_database !== want.found_database) begin
            $error("found_database: expected %0d, actual %0d",
                   want.found_database, rsp_ch.payload.found_database);
            error_count++;
          end
          if (rsp_ch.payload.found_slot !== want.found_slot) begin
            $error("found_slot: expected %0d, actual %0d",
                   want.found_slot, rsp_ch.payload.found_slot);
            error_count++;
          end
          if (rsp_ch.payload.found_type !== want.found_type) begin
            $error("found_type: expected %0d, actual %0d",
                   want.found_type, rsp_ch.payload.found_type);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        case (req_ch.payload.command)
          coal_pkg::CMD_WRITE_OBJECT: begin
            if (req_ch.payload.slot < coal_pkg::OBJECT_DEPTH_DEF) begin
              obj_table[req_ch.payload.slot] = '{
                req_ch.payload.iface_class, req_ch.payload.obis,
                (req_ch.payload.database >= coal_pkg::DATABASE_COUNT_DEF) ?
                  3'(coal_pkg::DATABASE_COUNT_DEF - 1) : req_ch.payload.database,
                req_ch.payload.first_member, req_ch.payload.attr_count,
                req_ch.payload.method_count};
            end
          end
          coal_pkg::CMD_WRITE_MEMBER: begin
            member_table[req_ch.payload.slot] = '{
              req_ch.payload.member_number, req_ch.payload.rights, req_ch.payload.data_type};
          end
          coal_pkg::CMD_LOOKUP: begin
            pending_results.push_back(row_pinned ? row_result : lookup_result(req_ch.payload));
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cosem_object_access_lookup_core_tb failed");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    ready_mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (ready_mode)
        0: rsp_ch.ready = 1'b1;
        1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
        2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready = (mode_left % 16 == 0);
      endcase
    end
  end

  initial begin
    coal_pkg::req_item_t  item;
    coal_pkg::obj_entry_t obj;
    logic [127:0]         noise;
    logic [63:0]          wide;
    logic [7:0]           base;
    logic [7:0]           count;
    logic [6:0]           phase_cfg [6];
    int                   lim;
    int                   pick;
    int                   idx;

    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    row_pinned = 1'b0;
    row_result = NOT_FOUND;
    scan_count = '0;
    error_count = 0;
    burst_left = 0;

    class_pool[0] = 16'h0000;
    class_pool[1] = 16'hFFFF;
    obis_pool[0] = 48'h0;
    obis_pool[1] = 48'hFFFF_FFFF_FFFF;
    for (int i = 2; i < 4; i++) begin
      class_pool[i] = 16'($urandom);
      wide = {$urandom, $urandom};
      obis_pool[i] = wide[47:0];
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int s = 0; s < coal_pkg::OBJECT_DEPTH_DEF; s++) begin
      send_request(make_request(coal_pkg::CMD_WRITE_OBJECT, 8'(s),
                                class_pool[$urandom_range(0, 3)],
                                obis_pool[$urandom_range(0, 3)], 3'($urandom),
                                8'($urandom), 8'($urandom_range(0, 4)),
                                8'($urandom_range(0, 4)), 8'd0, 2'd0, 8'd0,
                                coal_pkg::SVC_GET),
                   1'b0, NOT_FOUND);
    end
    for (int s = 0; s < coal_pkg::MEMBER_DEPTH_DEF; s++) begin
      send_request(make_request(coal_pkg::CMD_WRITE_MEMBER, 8'(s), 16'd0, 48'd0, 3'd0, 8'd0,
                                8'd0, 8'd0, 8'($urandom_range(0, 7)), 2'($urandom),
                                8'($urandom), coal_pkg::SVC_GET),
                   1'b0, NOT_FOUND);
    end

    directed_rows.push_back('{1'b1, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b1, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_OBJECT, 8'd0,
      16'hFFFF, 48'hFFFF_FFFF_FFFF, 3'd7, 8'd250, 8'd3, 8'd4, 8'd0, 2'd0, 8'd0,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd250,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1, coal_pkg::NEED_GET, 8'hAA,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd251,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd2, coal_pkg::NEED_SET, 8'hBB,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd252,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd255, coal_pkg::NEED_BOTH, 8'hFF,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd253,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd9, coal_pkg::NEED_GET, 8'h33,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd254,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd7, 2'd0, 8'h44, coal_pkg::SVC_GET),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd255,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, coal_pkg::NEED_BOTH, 8'h11,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_MEMBER, 8'd0,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd9, coal_pkg::NEED_BOTH, 8'h22,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b1, 7'd1, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'hAA}});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1, 2'd0, 8'd0, coal_pkg::SVC_SET),
      1'b1, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd2, 2'd0, 8'd0, coal_pkg::SVC_SET),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'hBB}});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd255, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'hFF}});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd9, 2'd0, 8'd0, coal_pkg::SVC_ACTION),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'h22}});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd7, 2'd0, 8'd0, coal_pkg::SVC_ACTION),
      1'b1, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1, 2'd0, 8'd0, SVC_UNUSED),
      1'b1, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(CMD_UNUSED, 8'hFF, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 8'hFF, SVC_UNUSED),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_OBJECT, 8'd255,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_OBJECT, 8'd64,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_OBJECT, 8'd1,
      16'hFFFF, 48'hFFFF_FFFF_FFFF, 3'd0, 8'd250, 8'd3, 8'd0, 8'd0, 2'd0, 8'd0,
      coal_pkg::SVC_GET), 1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b1, 7'd2, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'hAA}});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_WRITE_OBJECT, 8'd63,
      16'd0, 48'd0, 3'd0, 8'd0, 8'd255, 8'd255, 8'd0, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b1, 7'd127, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'd0,
      48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0, coal_pkg::SVC_ACTION),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b0, 7'd0, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'd0,
      48'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 2'd0, 8'd0, coal_pkg::SVC_GET),
      1'b0, NOT_FOUND});
    directed_rows.push_back('{1'b1, 7'd64, make_request(coal_pkg::CMD_LOOKUP, 8'd0, 16'hFFFF,
      48'hFFFF_FFFF_FFFF, 3'd0, 8'd0, 8'd0, 8'd0, 8'd2, 2'd0, 8'd0, coal_pkg::SVC_SET),
      1'b1, {coal_pkg::STATUS_FOUND, 3'd7, 6'd0, 8'hBB}});

    for (int r = 0; r < directed_rows.size(); r++) begin
      if (directed_rows[r].set_cfg) set_scan_count(directed_rows[r].cfg_value);
      send_request(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].result);
    end

    phase_cfg[0] = 7'd64;
    phase_cfg[1] = 7'($urandom_range(1, 63));
    phase_cfg[2] = 7'd127;
    phase_cfg[3] = 7'd0;
    phase_cfg[4] = 7'($urandom_range(65, 126));
    phase_cfg[5] = 7'($urandom_range(1, 64));

    for (int p = 0; p < 6; p++) begin
      set_scan_count(phase_cfg[p]);
      lim = (scan_count > coal_pkg::OBJECT_DEPTH_DEF) ? coal_pkg::OBJECT_DEPTH_DEF :
                                                        int'(scan_count);
      for (int n = 0; n < 18; n++) begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        item = noise[$bits(coal_pkg::req_item_t)-1:0];
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          item.command = coal_pkg::CMD_WRITE_OBJECT;
          item.slot = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(64, 255)) :
                                                    8'($urandom_range(0, 63));
          if ($urandom_range(0, 9) != 0) item.iface_class = class_pool[$urandom_range(0, 3)];
          if ($urandom_range(0, 9) != 0) item.obis = obis_pool[$urandom_range(0, 3)];
          if ($urandom_range(0, 29) != 0) item.attr_count = 8'($urandom_range(0, 5));
          if ($urandom_range(0, 29) != 0) item.method_count = 8'($urandom_range(0, 5));
        end else if (pick < 40) begin
          item.command = coal_pkg::CMD_WRITE_MEMBER;
          if ($urandom_range(0, 9) != 0) item.member_number = 8'($urandom_range(0, 7));
        end else if (pick < 95) begin
          item.command = coal_pkg::CMD_LOOKUP;
          item.service = ($urandom_range(0, 19) == 0) ? SVC_UNUSED : 2'($urandom_range(0, 2));
          if (lim > 0 && $urandom_range(0, 9) < 7) begin
            idx = $urandom_range(0, lim - 1);
            obj = obj_table[idx];
            item.iface_class = obj.iface_class;
            item.obis = obj.obis;
            if (item.service == coal_pkg::SVC_ACTION) begin
              base = obj.first_member + obj.attr_count;
              count = obj.method_count;
            end else begin
              base = obj.first_member;
              count = obj.attr_count;
            end
            if (count != 0) begin
              item.member_number = member_table[8'(base + 8'($urandom_range(0, count - 1)))].number;
            end else begin
              item.member_number = 8'($urandom_range(0, 7));
            end
          end else begin
            item.iface_class = ($urandom_range(0, 9) == 0) ? wide[63:48] :
                                                            class_pool[$urandom_range(0, 3)];
            item.obis = ($urandom_range(0, 9) == 0) ? wide[47:0] :
                                                     obis_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) != 0) item.member_number = 8'($urandom_range(0, 7));
          end
        end else begin
          item.command = CMD_UNUSED;
        end
        send_request(item, 1'b0, NOT_FOUND);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("cosem_object_access_lookup_core_tb passed");
    end else begin
      $display("cosem_object_access_lookup_core_tb failed");
    end
    $finish;
  end

endmodule
